// File: src/brxs_pkg.sv
`default_nettype none

package brxs_pkg;

    // Bytes in one chunk; also the depth of the block store.
    localparam int CHUNK = 20;

    // Fill counters hold 0 .. CHUNK; store addresses reach CHUNK-1.
    localparam int CNT_W = $clog2(CHUNK + 1);
    localparam int IDX_W = (CHUNK > 1) ? $clog2(CHUNK) : 1;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int KEY_BYTES = 24;
    localparam int KEY_W    = KEY_BYTES * BYTE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 2'd0,
        REG_KEY_LOW    = 2'd1,
        REG_KEY_MID    = 2'd2,
        REG_KEY_HIGH   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] plain_byte;
        logic              end_of_stream;
    } in_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] cipher_byte;
        logic              last_of_block;
    } out_req_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
    } mem_rd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] chunk_fill;
        logic [CNT_W-1:0] block_fill;
        logic [CNT_W-1:0] emit_count;
        logic [CNT_W-1:0] emit_len;
    } seq_status_t;

endpackage

`default_nettype wire

// File: src/brxs_store.sv
`default_nettype none

module brxs_store (
    input  wire logic                           clk,
    input  wire brxs_pkg::mem_wr_t              wr,
    input  wire brxs_pkg::mem_rd_t              rd,
    output logic [brxs_pkg::BYTE_W-1:0]         rd_data
);

    logic [brxs_pkg::BYTE_W-1:0] store_reg [brxs_pkg::CHUNK];
    logic [brxs_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.addr] <= wr.data;
        end
    end

    // The read data holds until the next read request.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= store_reg[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/brxs_seq.sv
`default_nettype none

module brxs_seq (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               in_valid,
    output logic                                                    in_ready,
    input  wire brxs_pkg::in_req_t                                  in_data,
    output logic                                                    out_valid,
    input  wire logic                                               out_ready,
    output brxs_pkg::out_req_t                                      out_data,
    input  wire logic [brxs_pkg::CNT_W-1:0]                         eff_len,
    input  wire logic [brxs_pkg::CHUNK-1:0][brxs_pkg::BYTE_W-1:0]   key_arr,
    output brxs_pkg::mem_wr_t                                       mem_wr,
    output brxs_pkg::mem_rd_t                                       mem_rd,
    input  wire logic [brxs_pkg::BYTE_W-1:0]                        mem_data,
    output brxs_pkg::seq_status_t                                   status
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_LOAD  = 3'b100
    } state_t;

    state_t                         state_reg, state_next;
    logic [brxs_pkg::CNT_W-1:0]     chunk_fill_reg, chunk_fill_next;
    logic [brxs_pkg::CNT_W-1:0]     block_fill_reg, block_fill_next;
    logic [brxs_pkg::CNT_W-1:0]     len_reg, len_next;
    logic [brxs_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [brxs_pkg::IDX_W-1:0]     cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    brxs_pkg::out_req_t             out_data_reg, out_data_next;

    logic [brxs_pkg::CNT_W-1:0]     chunk_inc;
    logic [brxs_pkg::CNT_W-1:0]     block_inc;
    logic [brxs_pkg::CNT_W-1:0]     cnt_inc;
    logic                           chunk_done;
    logic                           out_free;
    logic                           last_byte;

    assign chunk_inc  = chunk_fill_reg + brxs_pkg::CNT_W'(1);
    assign block_inc  = block_fill_reg + brxs_pkg::CNT_W'(1);
    assign cnt_inc    = brxs_pkg::CNT_W'(cnt_reg) + brxs_pkg::CNT_W'(1);
    assign chunk_done = in_data.end_of_stream || (chunk_inc == brxs_pkg::CNT_W'(brxs_pkg::CHUNK));
    assign out_free   = !out_valid_reg || out_ready;
    assign last_byte  = (cnt_inc == len_reg);

    always_comb
    begin
        state_next      = state_reg;
        chunk_fill_next = chunk_fill_reg;
        block_fill_next = block_fill_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        in_ready        = 1'b0;
        mem_wr.en       = 1'b0;
        mem_wr.addr     = chunk_fill_reg[brxs_pkg::IDX_W-1:0];
        mem_wr.data     = in_data.plain_byte;
        mem_rd.en       = 1'b0;
        mem_rd.addr     = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mem_wr.en = 1'b1;
                    if (chunk_done || (block_inc >= eff_len))
                    begin
                        // The block closes: read it back from its newest byte.
                        len_next        = block_inc;
                        idx_next        = chunk_fill_reg[brxs_pkg::IDX_W-1:0];
                        cnt_next        = '0;
                        block_fill_next = '0;
                        chunk_fill_next = chunk_done ? '0 : chunk_inc;
                        state_next      = S_FETCH;
                    end
                    else
                    begin
                        block_fill_next = block_inc;
                        chunk_fill_next = chunk_inc;
                    end
                end
            end
            S_FETCH:
            begin
                mem_rd.en  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.cipher_byte   = mem_data ^ key_arr[cnt_reg];
                    out_data_next.last_of_block = last_byte;
                    if (last_byte)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + brxs_pkg::IDX_W'(1);
                        idx_next   = idx_reg - brxs_pkg::IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            chunk_fill_reg <= '0;
            block_fill_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chunk_fill_reg <= chunk_fill_next;
            block_fill_reg <= block_fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.busy       = (state_reg != S_IDLE);
    assign status.chunk_fill = chunk_fill_reg;
    assign status.block_fill = block_fill_reg;
    assign status.emit_count = brxs_pkg::CNT_W'(cnt_reg);
    assign status.emit_len   = len_reg;

endmodule

`default_nettype wire

// File: src/block_reverse_xor_scrambler_core.sv
`default_nettype none

// Byte-stream scrambler. Plaintext bytes arrive one per request and are cut
// into chunks of CHUNK (20) bytes, each chunk into blocks of key_length bytes;
// a block also closes when its chunk fills or on end_of_stream. A closed block
// is sent out newest byte first, each byte XORed with the key byte at its
// output position, and its final byte carries last_of_block. A byte that does
// not close a block leaves in_ready high. After a byte that closes a block of
// len bytes, in_ready stays low while the block is read back: each byte takes
// a read of the 20-entry block store and then a load of the output register,
// and the load waits while the output stalls. Configuration writes belong in
// idle periods only.
module block_reverse_xor_scrambler_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire brxs_pkg::in_req_t                      in_data,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output brxs_pkg::out_req_t                          out_data,
    input  wire logic                                   cfg_we,
    input  wire logic [brxs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [brxs_pkg::CFG_W-1:0]             cfg_data
);

    logic [brxs_pkg::BYTE_W-1:0]                        key_length_reg;
    logic [brxs_pkg::CFG_W-1:0]                         key_low_reg;
    logic [brxs_pkg::CFG_W-1:0]                         key_mid_reg;
    logic [brxs_pkg::CFG_W-1:0]                         key_high_reg;

    logic [brxs_pkg::KEY_W-1:0]                         key_vec;
    logic [brxs_pkg::CHUNK-1:0][brxs_pkg::BYTE_W-1:0]   key_arr;
    logic [brxs_pkg::CNT_W-1:0]                         eff_len;

    brxs_pkg::mem_wr_t                                  mem_wr;
    brxs_pkg::mem_rd_t                                  mem_rd;
    logic [brxs_pkg::BYTE_W-1:0]                        mem_data;
    brxs_pkg::seq_status_t                              status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= brxs_pkg::BYTE_W'(1);
            key_low_reg    <= '0;
            key_mid_reg    <= '0;
            key_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (brxs_pkg::cfg_reg_t'(cfg_index))
                brxs_pkg::REG_KEY_LENGTH: key_length_reg <= cfg_data[brxs_pkg::BYTE_W-1:0];
                brxs_pkg::REG_KEY_LOW:    key_low_reg    <= cfg_data;
                brxs_pkg::REG_KEY_MID:    key_mid_reg    <= cfg_data;
                brxs_pkg::REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                default:                  key_low_reg    <= key_low_reg;
            endcase
        end
    end

    assign key_vec = {key_high_reg, key_mid_reg, key_low_reg};
    assign key_arr = key_vec[brxs_pkg::CHUNK*brxs_pkg::BYTE_W-1:0];

    // A zero length acts as one, and anything past a chunk acts as a chunk.
    always_comb
    begin
        if (key_length_reg == '0)
        begin
            eff_len = brxs_pkg::CNT_W'(1);
        end
        else if (key_length_reg >= brxs_pkg::BYTE_W'(brxs_pkg::CHUNK))
        begin
            eff_len = brxs_pkg::CNT_W'(brxs_pkg::CHUNK);
        end
        else
        begin
            eff_len = key_length_reg[brxs_pkg::CNT_W-1:0];
        end
    end

    brxs_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .eff_len   (eff_len),
        .key_arr   (key_arr),
        .mem_wr    (mem_wr),
        .mem_rd    (mem_rd),
        .mem_data  (mem_data),
        .status    (status)
    );

    brxs_store u_store (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_data)
    );

`ifndef ASSERT_OFF
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.chunk_fill < brxs_pkg::CNT_W'(brxs_pkg::CHUNK))
        else $error("chunk fill reached the chunk size without closing");

    a_block_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        status.block_fill <= status.chunk_fill)
        else $error("open block is longer than the open chunk");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> (status.emit_count < status.emit_len))
        else $error("read-back ran past the end of the block");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy |-> !in_ready)
        else $error("input accepted while a block is being emitted");
`endif

endmodule

`default_nettype wire
